// ----- design/eipl4_pkg.sv -----
// Shared types, constants and status codes for the Ethernet/IPv4/L4 header parser.
`default_nettype none
package eipl4_pkg;

    localparam logic [15:0] MAX_CAPTURE = 16'd65535;
    localparam logic [15:0] ETH_HDR_LEN = 16'd14;
    localparam logic [15:0] IP_MIN_LEN  = 16'd20;
    localparam logic [15:0] TCP_HDR_LEN = 16'd20;
    localparam logic [15:0] UDP_HDR_LEN = 16'd8;
    localparam logic [15:0] TYPE_IPV4   = 16'h0800;
    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;

    // Byte offsets of the header fields in the frame
    localparam logic [15:0] POS_TYPE_HI = 16'd12;
    localparam logic [15:0] POS_TYPE_LO = 16'd13;
    localparam logic [15:0] POS_IHL     = 16'd14;
    localparam logic [15:0] POS_PROTO   = 16'd23;
    localparam logic [15:0] POS_SRC_LO  = 16'd26;
    localparam logic [15:0] POS_SRC_HI  = 16'd29;
    localparam logic [15:0] POS_DST_LO  = 16'd30;
    localparam logic [15:0] POS_DST_HI  = 16'd33;
    localparam logic [15:0] POS_L4_MIN  = 16'd34;

    typedef enum logic [3:0] {
        ST_NON_IP       = 4'd0,
        ST_TCP          = 4'd1,
        ST_UDP          = 4'd2,
        ST_OTHER_IP     = 4'd3,
        ST_SHORT_ETH    = 4'd4,
        ST_SHORT_IP     = 4'd5,
        ST_BAD_IHL      = 4'd6,
        ST_SHORT_IP_HDR = 4'd7,
        ST_SHORT_TCP    = 4'd8,
        ST_SHORT_UDP    = 4'd9
    } eipl4_status_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [15:0] wire_length;
    } eipl4_in_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [15:0] eth_type;
        logic [7:0]  ip_protocol;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] frame_length;
    } eipl4_out_t;

    // Everything captured from one frame, handed from front to back
    typedef struct packed {
        logic [15:0] cap_len;
        logic [15:0] eth_type;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] wire_len;
    } eipl4_sum_t;

endpackage
`default_nettype wire

// ----- design/eipl4_front.sv -----
// Front end: accepts frame bytes, counts them and captures header fields.
`default_nettype none
module eipl4_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire logic                  q_full,
    input  wire eipl4_pkg::eipl4_in_t  frame_word,
    output logic                       q_push,
    output eipl4_pkg::eipl4_sum_t      q_data
);
    import eipl4_pkg::*;

    logic [15:0] count_reg, count_next;
    logic [15:0] type_reg, type_next;
    logic [3:0]  ihl_reg, ihl_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;
    logic [15:0] sport_reg, sport_next;
    logic [15:0] dport_reg, dport_next;

    logic        accept;
    logic        take;
    logic [15:0] pos;
    logic [15:0] l4;
    logic [7:0]  b;

    assign accept = push && !q_full;
    assign take   = accept && (count_reg < MAX_CAPTURE);
    assign pos    = count_reg;
    assign b      = frame_word.data_byte;
    assign l4     = ETH_HDR_LEN + {10'd0, ihl_reg, 2'b00};

    always_comb
    begin
        count_next = count_reg;
        type_next  = type_reg;
        ihl_next   = ihl_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        sport_next = sport_reg;
        dport_next = dport_reg;
        if (take)
        begin
            count_next = count_reg + 16'd1;
            if (pos == POS_TYPE_HI || pos == POS_TYPE_LO)
                type_next = {type_reg[7:0], b};
            if (pos == POS_IHL)
                ihl_next = b[3:0];
            if (pos == POS_PROTO)
                proto_next = b;
            if (pos >= POS_SRC_LO && pos <= POS_SRC_HI)
                src_next = {src_reg[23:0], b};
            if (pos >= POS_DST_LO && pos <= POS_DST_HI)
                dst_next = {dst_reg[23:0], b};
            if (pos >= POS_L4_MIN)
            begin
                if (pos == l4 || pos == l4 + 16'd1)
                    sport_next = {sport_reg[7:0], b};
                if (pos == l4 + 16'd2 || pos == l4 + 16'd3)
                    dport_next = {dport_reg[7:0], b};
            end
        end
    end

    // Hand the finished frame to the queue on the last byte
    assign q_push = accept && frame_word.last_byte;

    always_comb
    begin
        q_data.cap_len  = count_next;
        q_data.eth_type = type_next;
        q_data.ihl      = ihl_next;
        q_data.proto    = proto_next;
        q_data.src      = src_next;
        q_data.dst      = dst_next;
        q_data.sport    = sport_next;
        q_data.dport    = dport_next;
        q_data.wire_len = frame_word.wire_length;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            type_reg  <= '0;
            ihl_reg   <= '0;
            proto_reg <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
            sport_reg <= '0;
            dport_reg <= '0;
        end
        else if (q_push)
        begin
            // Clear for the next frame
            count_reg <= '0;
            type_reg  <= '0;
            ihl_reg   <= '0;
            proto_reg <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
            sport_reg <= '0;
            dport_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            type_reg  <= type_next;
            ihl_reg   <= ihl_next;
            proto_reg <= proto_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
            sport_reg <= sport_next;
            dport_reg <= dport_next;
        end
    end

endmodule
`default_nettype wire

// ----- design/eipl4_fifo.sv -----
// Two-entry queue of frame summaries between front and back.
`default_nettype none
module eipl4_fifo (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   wr_en,
    input  wire eipl4_pkg::eipl4_sum_t  wr_data,
    output logic                        q_full,
    input  wire logic                   rd_en,
    output logic                        q_empty,
    output eipl4_pkg::eipl4_sum_t       rd_data
);
    import eipl4_pkg::*;

    eipl4_sum_t  mem [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  fill_reg;

    assign q_full  = (fill_reg == 2'd2);
    assign q_empty = (fill_reg == 2'd0);
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (rd_en)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (wr_en && !rd_en)
                fill_reg <= fill_reg + 2'd1;
            else if (rd_en && !wr_en)
                fill_reg <= fill_reg - 2'd1;
        end
    end

endmodule
`default_nettype wire

// ----- design/eipl4_back.sv -----
// Back end: classifies a frame summary and holds the result word.
`default_nettype none
module eipl4_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_empty,
    input  wire eipl4_pkg::eipl4_sum_t  q_data,
    output logic                        q_pop,
    output logic                        empty,
    input  wire logic                   pop,
    output eipl4_pkg::eipl4_out_t       header_word
);
    import eipl4_pkg::*;

    logic          valid_reg;
    eipl4_out_t    word_reg;
    eipl4_out_t    word_next;
    eipl4_status_t status;
    logic          ip_ok;
    logic          ports_ok;
    logic [15:0]   l4;
    logic [15:0]   cap;

    assign cap = q_data.cap_len;
    assign l4  = ETH_HDR_LEN + {10'd0, q_data.ihl, 2'b00};

    always_comb
    begin
        ip_ok    = 1'b0;
        ports_ok = 1'b0;
        if (cap < ETH_HDR_LEN)
            status = ST_SHORT_ETH;
        else if (q_data.eth_type != TYPE_IPV4)
            status = ST_NON_IP;
        else if (cap < ETH_HDR_LEN + IP_MIN_LEN)
            status = ST_SHORT_IP;
        else if ({10'd0, q_data.ihl, 2'b00} < IP_MIN_LEN)
            status = ST_BAD_IHL;
        else if (cap < l4)
            status = ST_SHORT_IP_HDR;
        else
        begin
            ip_ok = 1'b1;
            if (q_data.proto == PROTO_TCP)
            begin
                ports_ok = (cap >= l4 + TCP_HDR_LEN);
                status   = ports_ok ? ST_TCP : ST_SHORT_TCP;
            end
            else if (q_data.proto == PROTO_UDP)
            begin
                ports_ok = (cap >= l4 + UDP_HDR_LEN);
                status   = ports_ok ? ST_UDP : ST_SHORT_UDP;
            end
            else
                status = ST_OTHER_IP;
        end

        word_next.status         = status;
        word_next.eth_type       = (status == ST_SHORT_ETH) ? 16'd0 : q_data.eth_type;
        word_next.ip_protocol    = ip_ok ? q_data.proto : 8'd0;
        word_next.source_address = ip_ok ? q_data.src : 32'd0;
        word_next.dest_address   = ip_ok ? q_data.dst : 32'd0;
        word_next.source_port    = ports_ok ? q_data.sport : 16'd0;
        word_next.dest_port      = ports_ok ? q_data.dport : 16'd0;
        word_next.frame_length   = q_data.wire_len;
    end

    // Refill the output register when it is free or being taken this cycle
    assign q_pop       = !q_empty && (!valid_reg || pop);
    assign empty       = !valid_reg;
    assign header_word = word_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop)
            word_reg <= word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (q_pop)
            valid_reg <= 1'b1;
        else if (pop)
            valid_reg <= 1'b0;
    end

endmodule
`default_nettype wire

// ----- design/eth_ipv4_l4_header_parser.sv -----
// Top level of the Ethernet/IPv4/TCP-UDP header parser.
//
// Input channel: one frame byte per word (data_byte, last_byte, wire_length),
// taken at a clock edge with push high and full low. A word is taken every
// cycle while full is low. The front end counts bytes (saturating at 65535)
// and captures ethertype, IHL, protocol, addresses and the L4 ports.
// On the last byte the front end pushes a frame summary into a two-entry
// queue and clears its capture registers, so the next frame may start in
// the very next cycle.
// Result channel: one word per frame. The back end classifies the head of
// the queue and loads the output register; a result shows with empty low when
// it lands in the output register and leaves at an edge with pop high.
// Throughput: one byte per cycle unless full; one frame per cycle while pop high.
// Stall: while pop is held low the output register holds, the queue fills,
// and full rises once two summaries wait; bytes are then held off.
// Reset (rst_n low, asynchronous) drops any partial frame and all queued and
// pending results.
`default_nettype none
module eth_ipv4_l4_header_parser (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire eipl4_pkg::eipl4_in_t  frame_word,
    output logic                       empty,
    input  wire logic                  pop,
    output eipl4_pkg::eipl4_out_t      header_word
);
    import eipl4_pkg::*;

    logic       q_full;
    logic       q_empty;
    logic       q_push;
    logic       q_pop;
    eipl4_sum_t q_wr_data;
    eipl4_sum_t q_rd_data;

    // Hold off bytes while the summary queue has no room
    assign full = q_full;

    eipl4_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .q_full     (q_full),
        .frame_word (frame_word),
        .q_push     (q_push),
        .q_data     (q_wr_data)
    );

    eipl4_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .q_empty (q_empty),
        .rd_data (q_rd_data)
    );

    eipl4_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (q_rd_data),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .header_word (header_word)
    );

endmodule
`default_nettype wire
